@@ rtl/core/apbctl_pkg.sv @@
`timescale 1ns / 1ps

package apbctl_pkg;

    // fixed word indexes
    localparam logic [7:0] IDX_CMD    = 8'd0;
    localparam logic [7:0] IDX_STATUS = 8'd1;
    localparam logic [7:0] IDX_LEVEL  = 8'd2;
    localparam logic [7:0] IDX_CFG    = 8'd3;
    localparam logic [7:0] IDX_COEF   = 8'd4;

    // most coefficient words the 8-bit index can reach
    localparam int COEF_REACH = 252;
    // most buffer words per parity bank the 8-bit index can reach
    localparam int BUF_REACH  = 128;

    // command codes
    localparam logic [31:0] OP_NOP    = 32'd0;
    localparam logic [31:0] OP_CLR    = 32'd1;
    localparam logic [31:0] OP_CFG    = 32'd2;
    localparam logic [31:0] OP_START  = 32'd4;
    localparam logic [31:0] OP_STOP   = 32'd5;
    localparam logic [31:0] OP_LEVEL  = 32'd8;
    localparam logic [31:0] OP_IRQACK = 32'd16;

    // status bits
    localparam logic [31:0] ST_PLAY    = 32'h0000_0001;
    localparam logic [31:0] ST_CMD_ERR = 32'h0000_0002;
    localparam logic [31:0] ST_CLR_ERR = 32'h0000_0004;
    localparam logic [31:0] ST_CFG_ERR = 32'h0000_0008;
    localparam logic [31:0] ST_IRQ_ERR = 32'h0000_0010;

    typedef struct packed {
        logic        sel;
        logic        ena;
        logic        wr;
        logic [7:0]  idx;
        logic [31:0] wdata;
        logic        req;
    } item_t;

    typedef struct packed {
        logic [31:0]        read_data;
        logic               ready_res;
        logic               interrupt;
        logic               playing;
        logic               clear_pulse;
        logic               config_pulse;
        logic               level_pulse;
        logic               tick;
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic [31:0]        config_word;
        logic [31:0]        level_word;
    } result_t;

    typedef struct packed {
        logic coef_we;
        logic even_we;
        logic odd_we;
        logic buf_clr;
    } mem_ctl_t;

endpackage

@@ rtl/core/apbctl_ram.sv @@
`timescale 1ns / 1ps

module apbctl_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      rd_reg;
    logic [31:0]      byp_reg;
    logic             hit_reg;
    logic [AW-1:0]    raddr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg    <= mem[raddr];
            raddr_reg <= raddr;
            hit_reg   <= we && (waddr == raddr);
            byp_reg   <= wdata;
        end
    end

    // entries never written since reset or clear read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = valid_reg[raddr_reg] ? (hit_reg ? byp_reg : rd_reg) : '0;

endmodule

@@ rtl/core/apbctl_core.sv @@
`timescale 1ns / 1ps

module apbctl_core #(
    parameter int BUFFER_FRAMES = 16,
    parameter int COEFF_WORDS   = 128,
    parameter int CMD_WAIT      = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 proc,
    input  apbctl_pkg::item_t                    item,
    input  logic [31:0]                          coef_rd,
    input  logic [31:0]                          even_bus_rd,
    input  logic [31:0]                          odd_bus_rd,
    input  logic [31:0]                          even_smp_rd,
    input  logic [31:0]                          odd_smp_rd,
    input  logic                                 smp_ok,
    output apbctl_pkg::result_t                  res,
    output apbctl_pkg::mem_ctl_t                 mem_ctl,
    output logic [$clog2(4*BUFFER_FRAMES)-1:0]   ptr_look
);

    import apbctl_pkg::*;

    localparam int PTR_W = $clog2(4*BUFFER_FRAMES);
    localparam int HALF  = 2*BUFFER_FRAMES;
    localparam int BUF0  = 4 + COEFF_WORDS;
    localparam int BANK  = BUF0 + 2*HALF;

    localparam logic [31:0]      BUF0_W   = 32'(BUF0);
    localparam logic [31:0]      BANK_W   = 32'(BANK);
    localparam logic             BUF0_PAR = 1'(BUF0 % 2);
    localparam logic [PTR_W-1:0] PTR_MID  = PTR_W'(HALF - 2);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2*HALF - 2);
    localparam logic [PTR_W-1:0] PTR_STEP = PTR_W'(2);
    localparam logic [2:0]       WAIT_MAX = 3'(CMD_WAIT);

    logic [2:0]       wait_reg, wait_next;
    logic             irq_reg, irq_next;
    logic             play_reg, play_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [31:0]      cmd_reg, cmd_next;
    logic [31:0]      status_reg, status_next;
    logic [31:0]      level_reg, level_next;
    logic [31:0]      cfg_reg, cfg_next;

    logic [7:0]  idx_eff;
    logic [31:0] idx_w;
    logic        is_coef, is_buf, buf_par;
    logic        do_write, do_cmd;
    logic        clr, cfg, lvl, start, stop, ack;
    logic        cmd_err, clr_err, cfg_err, irq_err;
    logic        st_evt;
    logic [31:0] st_upd;
    logic [31:0] rd;

    assign idx_eff  = item.sel ? item.idx : '0;
    assign idx_w    = {24'b0, idx_eff};
    assign is_coef  = (idx_w >= 32'(IDX_COEF)) && (idx_w < BUF0_W);
    assign is_buf   = (idx_w >= BUF0_W) && (idx_w < BANK_W);
    assign buf_par  = idx_eff[0] ^ BUF0_PAR;
    assign do_write = (wait_reg == '0) && item.sel && item.ena && item.wr;
    assign do_cmd   = do_write && (idx_eff == IDX_CMD);

    always_comb
    begin
        clr     = 1'b0;
        cfg     = 1'b0;
        lvl     = 1'b0;
        start   = 1'b0;
        stop    = 1'b0;
        ack     = 1'b0;
        cmd_err = 1'b0;
        clr_err = 1'b0;
        cfg_err = 1'b0;
        if (do_cmd)
        begin
            unique case (item.wdata)
                OP_NOP:    ;
                OP_CLR:
                begin
                    clr     = !play_reg;
                    clr_err = play_reg;
                end
                OP_CFG:
                begin
                    cfg     = !play_reg;
                    cfg_err = play_reg;
                end
                OP_LEVEL:  lvl   = 1'b1;
                OP_START:  start = 1'b1;
                OP_STOP:   stop  = 1'b1;
                OP_IRQACK: ack   = 1'b1;
                default:   cmd_err = 1'b1;
            endcase
        end
    end

    // bus read mux
    always_comb
    begin
        rd = '0;
        if (item.sel)
        begin
            if (idx_eff == IDX_CMD)
            begin
                rd = cmd_reg;
            end
            else if (idx_eff == IDX_STATUS)
            begin
                rd = status_reg;
            end
            else if (idx_eff == IDX_LEVEL)
            begin
                rd = level_reg;
            end
            else if (idx_eff == IDX_CFG)
            begin
                rd = cfg_reg;
            end
            else if (is_coef)
            begin
                rd = coef_rd;
            end
            else if (is_buf)
            begin
                rd = buf_par ? odd_bus_rd : even_bus_rd;
            end
        end
    end

    // command wait states
    always_comb
    begin
        wait_next = wait_reg;
        if (wait_reg == '0)
        begin
            if (item.sel && !item.ena && item.wr && (idx_eff == IDX_CMD))
            begin
                wait_next = 3'd1;
            end
        end
        else if (wait_reg < WAIT_MAX)
        begin
            wait_next = wait_reg + 3'd1;
        end
        else
        begin
            wait_next = '0;
        end
    end

    // half-buffer interrupt
    always_comb
    begin
        irq_err  = 1'b0;
        irq_next = irq_reg;
        if (!play_reg || stop)
        begin
            irq_next = 1'b0;
        end
        else if (ack)
        begin
            irq_next = 1'b0;
        end
        else if (pend_reg && ((ptr_reg == PTR_MID) || (ptr_reg == PTR_LAST)))
        begin
            irq_err  = irq_reg;
            irq_next = 1'b1;
        end
    end

    // status and fixed words
    assign st_evt = cmd_err || clr_err || cfg_err || irq_err || start || stop;

    always_comb
    begin
        st_upd = status_reg;
        if (cmd_err)
        begin
            st_upd = st_upd | ST_CMD_ERR;
        end
        if (clr_err)
        begin
            st_upd = st_upd | ST_CLR_ERR;
        end
        if (cfg_err)
        begin
            st_upd = st_upd | ST_CFG_ERR;
        end
        if (irq_err && !(do_write && (idx_eff == IDX_STATUS)))
        begin
            st_upd = st_upd | ST_IRQ_ERR;
        end
        if (start)
        begin
            st_upd = st_upd | ST_PLAY;
        end
        else if (stop)
        begin
            st_upd = st_upd & ~ST_PLAY;
        end
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        status_next = status_reg;
        level_next  = level_reg;
        cfg_next    = cfg_reg;
        if (do_write)
        begin
            if (idx_eff == IDX_CMD)
            begin
                cmd_next = item.wdata;
            end
            if (idx_eff == IDX_STATUS)
            begin
                status_next = item.wdata;
            end
            if (idx_eff == IDX_LEVEL)
            begin
                level_next = item.wdata;
            end
            if (idx_eff == IDX_CFG)
            begin
                cfg_next = item.wdata;
            end
        end
        if (st_evt)
        begin
            status_next = st_upd;
        end
    end

    assign play_next = start ? 1'b1 : (stop ? 1'b0 : play_reg);
    assign pend_next = play_reg && item.req;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (clr)
        begin
            ptr_next = '0;
        end
        else if (pend_reg)
        begin
            ptr_next = (ptr_reg < PTR_LAST) ? ptr_reg + PTR_STEP : '0;
        end
    end

    assign ptr_look = proc ? ptr_next : ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg   <= '0;
            irq_reg    <= 1'b0;
            play_reg   <= 1'b0;
            ptr_reg    <= '0;
            pend_reg   <= 1'b0;
            cmd_reg    <= '0;
            status_reg <= '0;
            level_reg  <= '0;
            cfg_reg    <= '0;
        end
        else if (proc)
        begin
            wait_reg   <= wait_next;
            irq_reg    <= irq_next;
            play_reg   <= play_next;
            ptr_reg    <= ptr_next;
            pend_reg   <= pend_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            level_reg  <= level_next;
            cfg_reg    <= cfg_next;
        end
    end

    always_comb
    begin
        res.read_data    = rd;
        res.ready_res    = (wait_reg == '0);
        res.interrupt    = irq_reg;
        res.playing      = play_reg;
        res.clear_pulse  = clr;
        res.config_pulse = cfg;
        res.level_pulse  = lvl;
        res.tick         = play_reg && pend_reg;
        res.left_sample  = smp_ok ? even_smp_rd[23:0] : '0;
        res.right_sample = smp_ok ? odd_smp_rd[23:0] : '0;
        res.config_word  = cfg_reg;
        res.level_word   = level_reg;
    end

    always_comb
    begin
        mem_ctl.coef_we = proc && do_write && is_coef;
        mem_ctl.even_we = proc && do_write && is_buf && !buf_par;
        mem_ctl.odd_we  = proc && do_write && is_buf && buf_par;
        mem_ctl.buf_clr = proc && clr;
    end

endmodule

@@ rtl/core/audio_port_bus_control_unit.sv @@
`timescale 1ns / 1ps

// channel  | valid      | stall     | word
// ---------+------------+-----------+--------------------------------------------------
// in       | in_valid   | in_stall  | select enable write_en reg_index write_data
//          |            |           | sample_request
// out      | out_valid  | out_stall | read_data ready_res interrupt playing pulses tick
//          |            |           | left/right_sample config_word level_word
//
// one word per cycle sustained unless out_stall holds a valid result; the result is registered in the output stage
// input stage: input register and registered reads of the coefficient and buffer rams
// output stage: decode, state update and result register
// reset clears the valid flags and core state at once; buffer and coefficient rams read zero until written
// in_stall rises only while both stages hold a word and out_stall is high

module audio_port_bus_control_unit #(
    parameter int BUFFER_FRAMES = 16,
    parameter int COEFF_WORDS   = 128,
    parameter int CMD_WAIT      = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               select,
    input  logic               enable,
    input  logic               write_en,
    input  logic [7:0]         reg_index,
    input  logic [31:0]        write_data,
    input  logic               sample_request,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        read_data,
    output logic               ready_res,
    output logic               interrupt,
    output logic               playing,
    output logic               clear_pulse,
    output logic               config_pulse,
    output logic               level_pulse,
    output logic               tick,
    output logic signed [23:0] left_sample,
    output logic signed [23:0] right_sample,
    output logic [31:0]        config_word,
    output logic [31:0]        level_word
);

    import apbctl_pkg::*;

    localparam int PTR_W = $clog2(4*BUFFER_FRAMES);
    localparam int BUF0  = 4 + COEFF_WORDS;
    localparam int NC    = (COEFF_WORDS < COEF_REACH) ? COEFF_WORDS : COEF_REACH;
    localparam int CIW   = (NC > 1) ? $clog2(NC) : 1;
    localparam int NE    = (2*BUFFER_FRAMES < BUF_REACH) ? 2*BUFFER_FRAMES : BUF_REACH;
    localparam int EIW   = $clog2(NE);

    localparam logic [31:0] BUF0_W = 32'(BUF0);
    localparam logic [31:0] NE_W   = 32'(NE);

    logic     s1_valid_reg, s1_valid_next;
    item_t    item_reg;
    logic     smp_ok_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  res, res_reg;
    mem_ctl_t mem_ctl;
    logic     in_fire, proc;

    logic [PTR_W-1:0] ptr_look;
    logic [PTR_W-2:0] smp_entry;
    logic [EIW-1:0]   smp_ra;
    logic             smp_ok_next;
    logic [31:0]      in_idx_w, s1_idx_w, in_boff, s1_boff, in_coff, s1_coff;
    logic [CIW-1:0]   coef_ra, coef_wa;
    logic [EIW-1:0]   buf_ra, buf_wa;
    logic [31:0]      coef_rd, even_bus_rd, odd_bus_rd, even_smp_rd, odd_smp_rd;

    // two-stage handshake
    assign proc           = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !proc;
    assign in_fire        = in_valid && !in_stall;
    assign s1_valid_next  = in_fire || (s1_valid_reg && !proc);
    assign out_valid_next = proc || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.sel   <= select;
            item_reg.ena   <= enable;
            item_reg.wr    <= write_en;
            item_reg.idx   <= reg_index;
            item_reg.wdata <= write_data;
            item_reg.req   <= sample_request;
            smp_ok_reg     <= smp_ok_next;
        end
        if (proc)
        begin
            res_reg <= res;
        end
    end

    // ram addresses
    assign in_idx_w = {24'b0, reg_index};
    assign s1_idx_w = {24'b0, item_reg.idx};
    assign in_coff  = in_idx_w - 32'(IDX_COEF);
    assign s1_coff  = s1_idx_w - 32'(IDX_COEF);
    assign in_boff  = in_idx_w - BUF0_W;
    assign s1_boff  = s1_idx_w - BUF0_W;
    assign coef_ra  = in_coff[CIW-1:0];
    assign coef_wa  = s1_coff[CIW-1:0];
    assign buf_ra   = in_boff[EIW:1];
    assign buf_wa   = s1_boff[EIW:1];

    // sample pair sits at the same entry of both parity banks
    assign smp_entry   = ptr_look[PTR_W-1:1];
    assign smp_ra      = EIW'(smp_entry);
    assign smp_ok_next = 32'(smp_entry) < NE_W;

    apbctl_ram #(.DEPTH(NC), .AW(CIW)) u_coef_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (1'b0),
        .we    (mem_ctl.coef_we),
        .waddr (coef_wa),
        .wdata (item_reg.wdata),
        .re    (in_fire),
        .raddr (coef_ra),
        .rdata (coef_rd)
    );

    apbctl_ram #(.DEPTH(NE), .AW(EIW)) u_even_bus_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mem_ctl.buf_clr),
        .we    (mem_ctl.even_we),
        .waddr (buf_wa),
        .wdata (item_reg.wdata),
        .re    (in_fire),
        .raddr (buf_ra),
        .rdata (even_bus_rd)
    );

    apbctl_ram #(.DEPTH(NE), .AW(EIW)) u_odd_bus_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mem_ctl.buf_clr),
        .we    (mem_ctl.odd_we),
        .waddr (buf_wa),
        .wdata (item_reg.wdata),
        .re    (in_fire),
        .raddr (buf_ra),
        .rdata (odd_bus_rd)
    );

    apbctl_ram #(.DEPTH(NE), .AW(EIW)) u_even_smp_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mem_ctl.buf_clr),
        .we    (mem_ctl.even_we),
        .waddr (buf_wa),
        .wdata (item_reg.wdata),
        .re    (in_fire),
        .raddr (smp_ra),
        .rdata (even_smp_rd)
    );

    apbctl_ram #(.DEPTH(NE), .AW(EIW)) u_odd_smp_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mem_ctl.buf_clr),
        .we    (mem_ctl.odd_we),
        .waddr (buf_wa),
        .wdata (item_reg.wdata),
        .re    (in_fire),
        .raddr (smp_ra),
        .rdata (odd_smp_rd)
    );

    apbctl_core #(
        .BUFFER_FRAMES (BUFFER_FRAMES),
        .COEFF_WORDS   (COEFF_WORDS),
        .CMD_WAIT      (CMD_WAIT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .proc        (proc),
        .item        (item_reg),
        .coef_rd     (coef_rd),
        .even_bus_rd (even_bus_rd),
        .odd_bus_rd  (odd_bus_rd),
        .even_smp_rd (even_smp_rd),
        .odd_smp_rd  (odd_smp_rd),
        .smp_ok      (smp_ok_reg),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .ptr_look    (ptr_look)
    );

    assign out_valid    = out_valid_reg;
    assign read_data    = res_reg.read_data;
    assign ready_res    = res_reg.ready_res;
    assign interrupt    = res_reg.interrupt;
    assign playing      = res_reg.playing;
    assign clear_pulse  = res_reg.clear_pulse;
    assign config_pulse = res_reg.config_pulse;
    assign level_pulse  = res_reg.level_pulse;
    assign tick         = res_reg.tick;
    assign left_sample  = res_reg.left_sample;
    assign right_sample = res_reg.right_sample;
    assign config_word  = res_reg.config_word;
    assign level_word   = res_reg.level_word;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty first stage");

    a_proc_out: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid_reg)
        else $error("processed word did not reach the output register");

    a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({clear_pulse, config_pulse, level_pulse}))
        else $error("more than one command pulse in one word");

    a_tick_play: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tick) |-> playing)
        else $error("tick outside play mode");

endmodule
